// File: hw/rtl/disc_coverage_marker_macros.svh
// assertion macros for the disc coverage marker
// expects clk and arst_n in the scope of the module that uses them
`ifndef DISC_COVERAGE_MARKER_MACROS_SVH
`define DISC_COVERAGE_MARKER_MACROS_SVH

// condition holds in the same cycle
`define DCM_CHECK_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// condition holds in the next cycle
`define DCM_CHECK_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/dcm_pkg.sv
// shared constants and types of the disc coverage marker
// no dependencies
package dcm_pkg;
	localparam int MAX_COLUMNS = 256;
	localparam int MAX_ROWS    = 256;
	localparam int MAX_RADIUS  = 32;

	localparam int RAD_W  = 6;
	localparam int GRID_W = 9;
	localparam int POS_W  = 16;
	localparam int NEW_W  = 13;
	localparam int TOT_W  = 17;
	localparam int SUM_W  = POS_W + 1;

	localparam int OFS_W = $clog2(MAX_RADIUS) + 1;
	localparam int RQ_W  = $clog2(MAX_RADIUS + 1);
	localparam int SQ_W  = 2 * OFS_W + 1;

	localparam int MAP_CELLS = MAX_COLUMNS * MAX_ROWS;
	localparam int MAP_AW    = $clog2(MAP_CELLS);
	localparam int COL_B     = $clog2(MAX_COLUMNS);
	localparam int ROW_B     = $clog2(MAX_ROWS);

	localparam int NEW_MAX = (1 << NEW_W) - 1;
	localparam int TOT_MAX = (1 << TOT_W) - 1;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;
	localparam logic [1:0] REG_RADIUS  = 2'd0;
	localparam logic [1:0] REG_COLUMNS = 2'd1;
	localparam logic [1:0] REG_ROWS    = 2'd2;

	typedef struct packed {
		logic              vld;
		logic              kept;
		logic [MAP_AW-1:0] addr;
	} dcm_look_t;

	typedef struct packed {
		logic busy;
		logic fresh;
		logic vld_s2;
	} dcm_map_stat_t;
endpackage

// File: hw/rtl/dcm_ifs.sv
// valid/ready channel interfaces for footprint positions and coverage results
// depends on dcm_pkg
interface dcm_item_if;
	import dcm_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] center_col;
	logic signed [POS_W-1:0] center_row;
	modport source (output valid, output center_col, output center_row, input ready);
	modport sink (input valid, input center_col, input center_row, output ready);
endinterface

interface dcm_result_if;
	import dcm_pkg::*;
	logic             valid;
	logic             ready;
	logic [NEW_W-1:0] newly_covered;
	logic [TOT_W-1:0] total_covered;
	modport source (output valid, output newly_covered, output total_covered, input ready);
	modport sink (input valid, input newly_covered, input total_covered, output ready);
endinterface

// File: hw/rtl/disc_coverage_marker.sv
// disc coverage marker top level: apb registers, offset sequencer, result register
// depends on dcm_pkg, dcm_ifs, dcm_cell_unit, dcm_cover_map, macros header
//
// item: one beat per footprint centre (center_col, center_row), signed cells.
// result: one beat per item with newly_covered and the running total_covered.
// apb: radius_cells at 0x0, grid_columns at 0x4, grid_rows at 0x8; write only
//   while no item is in flight.
// an item walks a 2R by 2R square of offsets, one offset per cycle through the
//   single cell evaluator and the map read-modify-write port; the result is
//   registered once the map pipeline has drained, and the next item is accepted
//   only after the sequencer is back in idle.
// item.ready is high only while the sequencer is idle; a new item is taken while
//   an earlier result still waits in the output register.
// if result.ready stays low, a finished item waits in the sequencer until the
//   output register is free, and no new item is accepted.
// after reset the coverage map is swept to zero, one cell per cycle, over all
//   MAX_COLUMNS*MAX_ROWS (65536) cells; item.ready stays low during the sweep.
//   apb writes are taken during the sweep.
module disc_coverage_marker (
	input  logic                          clk,
	input  logic                          arst_n,
	dcm_item_if.sink                      item,
	dcm_result_if.source                  result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dcm_pkg::APB_AW-1:0]    paddr,
	input  logic [dcm_pkg::APB_DW-1:0]    pwdata,
	output logic [dcm_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import dcm_pkg::*;
	`include "disc_coverage_marker_macros.svh"

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_DONE  = 3'd3;

	logic [RAD_W-1:0]        radius_q;
	logic [GRID_W-1:0]       cols_q;
	logic [GRID_W-1:0]       rows_q;
	logic [2:0]              state_q;
	logic signed [POS_W-1:0] cc_q;
	logic signed [POS_W-1:0] cr_q;
	logic [SQ_W-1:0]         r2_q;
	logic signed [OFS_W-1:0] lo_q;
	logic signed [OFS_W-1:0] hi_q;
	logic signed [OFS_W-1:0] dx_q;
	logic signed [OFS_W-1:0] dy_q;
	logic [NEW_W-1:0]        fresh_q;
	logic [TOT_W-1:0]        total_q;
	logic                    out_vld_q;
	logic [NEW_W-1:0]        out_new_q;
	logic [TOT_W-1:0]        out_tot_q;
	dcm_look_t               look_s1;
	dcm_map_stat_t           map_stat;

	logic                    cfg_wr;
	logic                    accept;
	logic [RQ_W-1:0]         r_eff;
	logic                    kept;
	logic [MAP_AW-1:0]       addr;
	logic [TOT_W:0]          tot_sum;
	logic [TOT_W-1:0]        tot_next;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign item.ready = (state_q == ST_IDLE) && !map_stat.busy;
	assign accept = item.valid && item.ready;

	always_comb begin
		r_eff = (32'(radius_q) > MAX_RADIUS) ? RQ_W'(MAX_RADIUS) : RQ_W'(radius_q);
		tot_sum = {1'b0, total_q} + (TOT_W + 1)'(fresh_q);
		tot_next = (tot_sum > (TOT_W + 1)'(TOT_MAX)) ? TOT_W'(TOT_MAX) : tot_sum[TOT_W-1:0];
	end

	always_comb begin
		case (paddr[APB_AW-1:2])
			REG_RADIUS:  prdata = APB_DW'(radius_q);
			REG_COLUMNS: prdata = APB_DW'(cols_q);
			REG_ROWS:    prdata = APB_DW'(rows_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RAD_W'(4);
			cols_q   <= GRID_W'(256);
			rows_q   <= GRID_W'(256);
		end else if (cfg_wr) begin
			case (paddr[APB_AW-1:2])
				REG_RADIUS:  radius_q <= pwdata[RAD_W-1:0];
				REG_COLUMNS: cols_q   <= pwdata[GRID_W-1:0];
				REG_ROWS:    rows_q   <= pwdata[GRID_W-1:0];
				default: begin
				end
			endcase
		end
	end

	dcm_cell_unit u_cell (
		.center_col   (cc_q),
		.center_row   (cr_q),
		.dx           (dx_q),
		.dy           (dy_q),
		.grid_columns (cols_q),
		.grid_rows    (rows_q),
		.r2           (r2_q),
		.kept         (kept),
		.addr         (addr)
	);

	dcm_cover_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.look_s1 (look_s1),
		.stat    (map_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cc_q      <= '0;
			cr_q      <= '0;
			r2_q      <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			dx_q      <= '0;
			dy_q      <= '0;
			fresh_q   <= '0;
			total_q   <= '0;
			out_vld_q <= 1'b0;
			out_new_q <= '0;
			out_tot_q <= '0;
			look_s1   <= '0;
		end else begin
			look_s1.vld  <= (state_q == ST_SCAN);
			look_s1.kept <= kept;
			look_s1.addr <= addr;

			if (map_stat.fresh && (fresh_q != NEW_W'(NEW_MAX))) begin
				fresh_q <= fresh_q + 1'b1;
			end

			if (out_vld_q && result.ready && (state_q != ST_DONE)) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cc_q    <= item.center_col;
						cr_q    <= item.center_row;
						r2_q    <= SQ_W'(r_eff) * SQ_W'(r_eff);
						lo_q    <= OFS_W'(-$signed({1'b0, r_eff}));
						hi_q    <= OFS_W'($signed({1'b0, r_eff}) - 1);
						dx_q    <= OFS_W'(-$signed({1'b0, r_eff}));
						dy_q    <= OFS_W'(-$signed({1'b0, r_eff}));
						fresh_q <= '0;
						state_q <= (r_eff == '0) ? ST_DRAIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (dy_q == hi_q) begin
						dy_q <= lo_q;
						if (dx_q == hi_q) begin
							state_q <= ST_DRAIN;
						end else begin
							dx_q <= dx_q + 1'b1;
						end
					end else begin
						dy_q <= dy_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!look_s1.vld && !map_stat.vld_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_vld_q || result.ready) begin
						out_vld_q <= 1'b1;
						out_new_q <= fresh_q;
						out_tot_q <= tot_next;
						total_q   <= tot_next;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid         = out_vld_q;
	assign result.newly_covered = out_new_q;
	assign result.total_covered = out_tot_q;

	`DCM_CHECK_NEXT(a_busy_after_accept, item.valid && item.ready, !item.ready, "ready high after accepted beat")
	`DCM_CHECK_NOW(a_done_pipe_empty, state_q == ST_DONE, !look_s1.vld && !map_stat.vld_s2, "result taken with cells in flight")
	`DCM_CHECK_NOW(a_no_ready_clear, map_stat.busy, !item.ready, "ready high during map sweep")
	`DCM_CHECK_NOW(a_fresh_when_working, map_stat.fresh, state_q == ST_SCAN || state_q == ST_DRAIN, "cell marked outside a scan")
endmodule

// File: hw/rtl/dcm_cell_unit.sv
// shared cell evaluator: grid bounds, disc test and map address for one offset
// depends on dcm_pkg
module dcm_cell_unit (
	input  logic signed [dcm_pkg::POS_W-1:0]  center_col,
	input  logic signed [dcm_pkg::POS_W-1:0]  center_row,
	input  logic signed [dcm_pkg::OFS_W-1:0]  dx,
	input  logic signed [dcm_pkg::OFS_W-1:0]  dy,
	input  logic        [dcm_pkg::GRID_W-1:0] grid_columns,
	input  logic        [dcm_pkg::GRID_W-1:0] grid_rows,
	input  logic        [dcm_pkg::SQ_W-1:0]   r2,
	output logic                              kept,
	output logic        [dcm_pkg::MAP_AW-1:0] addr
);
	import dcm_pkg::*;

	logic signed [SUM_W-1:0]   col;
	logic signed [SUM_W-1:0]   row;
	logic signed [2*OFS_W-1:0] dx2;
	logic signed [2*OFS_W-1:0] dy2;
	logic        [SQ_W-1:0]    sq_sum;
	logic                      col_ok;
	logic                      row_ok;

	always_comb begin
		col = SUM_W'(center_col) + SUM_W'(dx);
		row = SUM_W'(center_row) + SUM_W'(dy);
		col_ok = !col[SUM_W-1] && (col < $signed({1'b0, grid_columns}))
			&& (col < SUM_W'(MAX_COLUMNS));
		row_ok = !row[SUM_W-1] && (row < $signed({1'b0, grid_rows}))
			&& (row < SUM_W'(MAX_ROWS));
		dx2 = dx * dx;
		dy2 = dy * dy;
		sq_sum = SQ_W'($unsigned(dx2)) + SQ_W'($unsigned(dy2));
		kept = col_ok && row_ok && (sq_sum <= r2);
		addr = MAP_AW'(32'(row[ROW_B-1:0]) * MAX_COLUMNS + 32'(col[COL_B-1:0]));
	end
endmodule

// File: hw/rtl/dcm_cover_map.sv
// coverage bit map with clearing pass after reset and test-and-set pipeline
// depends on dcm_pkg
module dcm_cover_map (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dcm_pkg::dcm_look_t     look_s1,
	output dcm_pkg::dcm_map_stat_t stat
);
	import dcm_pkg::*;

	logic              mem [MAP_CELLS];
	logic              rd_s2;
	dcm_look_t         look_s2;
	logic              busy_q;
	logic [MAP_AW-1:0] clr_q;
	logic              set;

	assign set = look_s2.vld && look_s2.kept && !rd_s2;

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= 1'b0;
		end else if (set) begin
			mem[look_s2.addr] <= 1'b1;
		end
		rd_s2 <= mem[look_s1.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_s2 <= '0;
			busy_q  <= 1'b1;
			clr_q   <= '0;
		end else begin
			look_s2 <= look_s1;
			if (busy_q) begin
				if (clr_q == MAP_AW'(MAP_CELLS - 1)) begin
					busy_q <= 1'b0;
				end else begin
					clr_q <= clr_q + 1'b1;
				end
			end
		end
	end

	assign stat.busy   = busy_q;
	assign stat.fresh  = set;
	assign stat.vld_s2 = look_s2.vld;
endmodule

// File: bench/testbench.sv
// self-checking bench for disc_coverage_marker: footprint centres in, coverage counts out
// keeps its own coverage map and running total, and checks every result beat against them
// depends on dcm_pkg, dcm_ifs and the disc_coverage_marker rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dcm_pkg::*;

	localparam int WATCHDOG_LIMIT = 250000;
	localparam int SETTLE_CYCLES  = 4200;
	localparam int REPORT_LIMIT   = 10;

	typedef struct {
		logic signed [POS_W-1:0] col;
		logic signed [POS_W-1:0] row;
	} center_t;

	typedef struct {
		logic [NEW_W-1:0] newly;
		logic [TOT_W-1:0] total;
	} coverage_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	dcm_item_if   item_bus ();
	dcm_result_if result_bus ();

	disc_coverage_marker dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// bench copy of the registers and of the coverage state
	logic [RAD_W-1:0]  radius_reg;
	logic [GRID_W-1:0] columns_reg;
	logic [GRID_W-1:0] rows_reg;
	bit                covered_cells [MAP_CELLS];
	int                covered_sum;

	center_t   center_q [$];
	coverage_t coverage_due_q [$];
	coverage_t due_beat;
	center_t   next_center;

	int   items_issued;
	int   results_seen;
	int   mismatch_count;
	int   quiet_cycles;
	int   send_gap;
	int   take_gap;
	bit   steady;
	bit   item_fire;
	bit   res_fire;
	logic send_valid;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic coverage_t mark_footprint(logic signed [POS_W-1:0] cc,
			logic signed [POS_W-1:0] cr);
		int        r;
		int        cols;
		int        rows;
		int        col;
		int        row;
		int        fresh;
		coverage_t res;
		r     = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
		cols  = (columns_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(columns_reg);
		rows  = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
		fresh = 0;
		for (int dx = -r; dx < r; dx++) begin
			col = int'(cc) + dx;
			if (col >= 0 && col < cols) begin
				for (int dy = -r; dy < r; dy++) begin
					row = int'(cr) + dy;
					if (row >= 0 && row < rows && dx * dx + dy * dy <= r * r) begin
						if (!covered_cells[row * MAX_COLUMNS + col]) begin
							covered_cells[row * MAX_COLUMNS + col] = 1'b1;
							fresh++;
						end
					end
				end
			end
		end
		covered_sum = covered_sum + fresh;
		if (covered_sum > TOT_MAX)
			covered_sum = TOT_MAX;
		res.newly = (fresh > NEW_MAX) ? NEW_MAX[NEW_W-1:0] : fresh[NEW_W-1:0];
		res.total = covered_sum[TOT_W-1:0];
		return res;
	endfunction

	function automatic void note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// sampling side: predict on item beats, check result beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_fire    <= 1'b0;
			res_fire     <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			item_fire <= item_bus.valid && item_bus.ready;
			res_fire  <= result_bus.valid && result_bus.ready;
			if (result_bus.valid && result_bus.ready) begin
				if (coverage_due_q.size() == 0) begin
					note_mismatch($sformatf("result beat with no item pending: new %0d total %0d",
						result_bus.newly_covered, result_bus.total_covered));
				end else begin
					due_beat = coverage_due_q.pop_front();
					results_seen++;
					if (result_bus.newly_covered !== due_beat.newly
							|| result_bus.total_covered !== due_beat.total)
						note_mismatch($sformatf(
							"result %0d: newly_covered exp %0d got %0d, total_covered exp %0d got %0d",
							results_seen, due_beat.newly, result_bus.newly_covered,
							due_beat.total, result_bus.total_covered));
				end
			end
			if (item_bus.valid && item_bus.ready)
				coverage_due_q = {coverage_due_q,
					mark_footprint(item_bus.center_col, item_bus.center_row)};
			if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("disc_coverage_marker: mismatch");
			$finish;
		end
	end

	// item sender
	always @(negedge clk) begin
		if (arst_n) begin
			send_valid = item_bus.valid;
			if (item_fire) begin
				send_valid = 1'b0;
				send_gap   = steady ? 0 : $urandom_range(0, 16);
			end
			if (!send_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (center_q.size() > 0) begin
					next_center = center_q.pop_front();
					send_valid  = 1'b1;
					item_bus.center_col <= next_center.col;
					item_bus.center_row <= next_center.row;
				end
			end
			item_bus.valid <= send_valid;
		end
	end

	// result receiver stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_fire)
				take_gap = steady ? 0 : $urandom_range(0, 16);
			else if (take_gap > 0)
				take_gap--;
			result_bus.ready <= (take_gap == 0);
		end
	end

	task automatic queue_center(input int col, input int row);
		center_t c;
		c.col = col[POS_W-1:0];
		c.row = row[POS_W-1:0];
		center_q = {center_q, c};
		items_issued++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (results_seen != items_issued)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int unsigned value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_RADIUS:  radius_reg  = value[RAD_W-1:0];
			REG_COLUMNS: columns_reg = value[GRID_W-1:0];
			REG_ROWS:    rows_reg    = value[GRID_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int unsigned r, input int unsigned cols,
			input int unsigned rows);
		wait_idle();
		write_reg(REG_RADIUS, r);
		write_reg(REG_COLUMNS, cols);
		write_reg(REG_ROWS, rows);
	endtask

	initial begin
		int r;
		int cols;
		int rows;
		int rr;
		int ec;
		int er;
		int pc;
		int pr;
		int kind;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		item_bus.valid      = 1'b0;
		item_bus.center_col = '0;
		item_bus.center_row = '0;
		result_bus.ready    = 1'b0;
		radius_reg          = 6'd4;
		columns_reg         = 9'd256;
		rows_reg            = 9'd256;
		covered_sum         = 0;
		items_issued        = 0;
		results_seen        = 0;
		mismatch_count      = 0;
		send_gap            = 0;
		take_gap            = 0;
		steady              = 1'b0;
		pc                  = 0;
		pr                  = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: corners, far outside, repeat, edge overlap on left and right
		queue_center(0, 0);
		queue_center(255, 255);
		queue_center(-32768, -32768);
		queue_center(32767, 32767);
		queue_center(0, 0);
		queue_center(-3, 100);
		queue_center(-4, 100);
		queue_center(259, 10);
		// zero radius
		configure(0, 256, 256);
		queue_center(50, 50);
		queue_center(-1, -1);
		// radius and grid above their limits
		configure(63, 511, 300);
		queue_center(128, 128);
		queue_center(-20, 255);
		// empty grid along one axis, then a grid one row high
		configure(32, 0, 5);
		queue_center(2, 2);
		configure(33, 5, 0);
		queue_center(2, 2);
		configure(1, 300, 1);
		queue_center(200, 0);
		queue_center(0, 0);
		// grid resized keeps earlier marks
		configure(6, 40, 40);
		queue_center(38, 38);
		configure(6, 256, 256);
		queue_center(38, 38);
		queue_center(38, 38);
		configure(32, 256, 256);
		queue_center(200, 60);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			steady = (ph == 3);
			r    = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 9);
			cols = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 256);
			rows = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 256);
			configure(r, cols, rows);
			rr = (r > MAX_RADIUS) ? MAX_RADIUS : r;
			ec = (cols > MAX_COLUMNS) ? MAX_COLUMNS : cols;
			er = (rows > MAX_ROWS) ? MAX_ROWS : rows;
			for (int k = 0; k < 20; k++) begin
				// in odd phases, halfway through, the sender holds off until every result is back
				if (k == 10 && ph % 2 == 1)
					wait_idle();
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					pc = $urandom;
					pr = $urandom;
				end else if (kind > 1) begin
					pc = int'($urandom_range(0, ec + 2 * rr + 3)) - rr - 2;
					pr = int'($urandom_range(0, er + 2 * rr + 3)) - rr - 2;
				end
				queue_center(pc, pr);
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("disc_coverage_marker: match");
		else
			$display("disc_coverage_marker: mismatch");
		$finish;
	end
endmodule
